// ===== rtl/core/indexed_ordered_list_core_macros.svh =====
// ----------------------------------------------------------------------------
// Indexed ordered list assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_CORE_MACROS_SVH
`define INDEXED_ORDERED_LIST_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IOL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed ordered list check failed");

// The consequent must hold in the cycle after the antecedent.
`define IOL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed ordered list check failed");

`endif

// ===== rtl/core/iol_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed ordered list package
// Item layouts, operation and status codes, and the cell command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package iol_pkg;

  localparam int POS_W      = 5;
  localparam int IN_VALUE_W = 32;
  localparam int FOUND_W    = 4;
  localparam int COUNT_W    = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]                   op;
    logic [POS_W-1:0]             position;
    logic signed [IN_VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FOUND_W-1:0] found_position;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic load;
    logic shift;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/iol_in_if.sv =====
// ----------------------------------------------------------------------------
// Indexed ordered list operation channel
// Valid/ready channel that carries one list operation per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface iol_in_if;
  logic             valid;
  logic             ready;
  iol_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/iol_out_if.sv =====
// ----------------------------------------------------------------------------
// Indexed ordered list result channel
// Valid/ready channel that carries one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface iol_out_if;
  logic              valid;
  logic              ready;
  iol_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/iol_cell.sv =====
// ----------------------------------------------------------------------------
// Indexed ordered list cell
// Holds one list entry and its match flag, and trades them with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module iol_cell #(
  parameter int IDX        = 0,
  parameter int CNT_W      = 5,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire iol_pkg::cell_cmd_t    cmd,
  input  wire logic [CNT_W-1:0]      pos,
  input  wire logic [CNT_W-1:0]      cnt,
  input  wire logic [VALUE_BITS-1:0] value_in,
  input  wire logic [VALUE_BITS-1:0] left_data,
  input  wire logic [VALUE_BITS-1:0] right_data,
  input  wire logic                  right_match,
  output logic [VALUE_BITS-1:0]      data,
  output logic                       match
);
  import iol_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [VALUE_BITS-1:0] data_r;
  logic [VALUE_BITS-1:0] data_nxt;
  logic                  match_r;
  logic                  match_nxt;

  always_comb begin
    data_nxt = data_r;
    priority if (cmd.ins) begin
      if (IDX_C == pos) begin
        data_nxt = value_in;
      end else if (IDX_C > pos) begin
        data_nxt = left_data;
      end
    end else if (cmd.del && (IDX_C >= pos)) begin
      data_nxt = right_data;
    end
  end

  always_comb begin
    match_nxt = match_r;
    priority if (cmd.load) begin
      match_nxt = (data_r == value_in) && (IDX_C < cnt);
    end else if (cmd.shift) begin
      match_nxt = right_match;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

`default_nettype wire

// ===== rtl/core/iol_ctrl.sv =====
// ----------------------------------------------------------------------------
// Indexed ordered list controller
// Checks each operation, drives the cell row and builds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module iol_ctrl #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  iol_in_if.sink                in_item,
  iol_out_if.source             out_item,
  input  wire logic             match_head,
  output iol_pkg::cell_cmd_t    cmd,
  output logic [CNT_W-1:0]      cell_pos,
  output logic [CNT_W-1:0]      cnt
);
  import iol_pkg::*;

  localparam int WIDE = CNT_W + POS_W;

  typedef enum logic [0:0] {S_IDLE, S_SCAN} state_t;

  state_t           state_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] scan_r;

  logic             accept;
  logic [WIDE-1:0]  pos_w;
  logic [WIDE-1:0]  cnt_w;
  logic             ins_ok;
  logic             del_ok;
  logic             is_search;
  logic             scan_last;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] scan_inc;

  function automatic logic [COUNT_W-1:0] fit_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] t;
    t = (CNT_W+COUNT_W)'(c);
    return t[COUNT_W-1:0];
  endfunction

  function automatic logic [FOUND_W-1:0] fit_found(input logic [CNT_W-1:0] c);
    logic [CNT_W+FOUND_W-1:0] t;
    t = (CNT_W+FOUND_W)'(c);
    return t[FOUND_W-1:0];
  endfunction

  assign in_item.ready = (state_r == S_IDLE) && (!out_valid_r || out_item.ready);
  assign accept        = in_item.valid && in_item.ready;

  assign pos_w     = WIDE'(in_item.data.position);
  assign cnt_w     = WIDE'(cnt_r);
  assign ins_ok    = (in_item.data.op == OP_INSERT) && (cnt_w < WIDE'(DEPTH)) &&
                     (pos_w <= cnt_w);
  assign del_ok    = (in_item.data.op == OP_DELETE) && (pos_w < cnt_w);
  assign is_search = (in_item.data.op == OP_SEARCH);

  assign cnt_inc   = CNT_W'(cnt_r + 1'b1);
  assign cnt_dec   = CNT_W'(cnt_r - 1'b1);
  assign scan_inc  = CNT_W'(scan_r + 1'b1);
  assign scan_last = ({1'b0, scan_r} + 1'b1) == {1'b0, cnt_r};

  assign cmd.ins   = accept && ins_ok;
  assign cmd.del   = accept && del_ok;
  assign cmd.load  = accept && is_search;
  assign cmd.shift = (state_r == S_SCAN) && !match_head && !scan_last;
  assign cell_pos  = pos_w[CNT_W-1:0];
  assign cnt       = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      scan_r      <= '0;
    end else begin
      if (out_valid_r && out_item.ready && !accept) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_data_r.found_position <= '0;
            priority if (ins_ok) begin
              cnt_r                <= cnt_inc;
              out_valid_r          <= 1'b1;
              out_data_r.status    <= ST_DONE;
              out_data_r.count     <= fit_count(cnt_inc);
            end else if (del_ok) begin
              cnt_r                <= cnt_dec;
              out_valid_r          <= 1'b1;
              out_data_r.status    <= ST_DONE;
              out_data_r.count     <= fit_count(cnt_dec);
            end else if (is_search && (cnt_r != '0)) begin
              state_r              <= S_SCAN;
              scan_r               <= '0;
              out_valid_r          <= 1'b0;
            end else if (is_search) begin
              out_valid_r          <= 1'b1;
              out_data_r.status    <= ST_MISSING;
              out_data_r.count     <= fit_count(cnt_r);
            end else begin
              out_valid_r          <= 1'b1;
              out_data_r.status    <= ST_REJECT;
              out_data_r.count     <= fit_count(cnt_r);
            end
          end
        end
        S_SCAN: begin
          priority if (match_head) begin
            state_r                   <= S_IDLE;
            out_valid_r               <= 1'b1;
            out_data_r.status         <= ST_DONE;
            out_data_r.found_position <= fit_found(scan_r);
            out_data_r.count          <= fit_count(cnt_r);
          end else if (scan_last) begin
            state_r                   <= S_IDLE;
            out_valid_r               <= 1'b1;
            out_data_r.status         <= ST_MISSING;
            out_data_r.found_position <= '0;
            out_data_r.count          <= fit_count(cnt_r);
          end else begin
            scan_r                    <= scan_inc;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_item.valid = out_valid_r;
  assign out_item.data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/indexed_ordered_list_core.sv =====
// ----------------------------------------------------------------------------
// Indexed ordered list core
// Ordered list of signed values with insert and delete by position and search by value.
// ----------------------------------------------------------------------------
// Operations arrive as items on in_item (op, position, value) and each one
// returns exactly one item on out_item (status, found_position, count).
// The list is a row of DEPTH cells, one entry per cell. An insert shifts the
// cells above the position up by one, and a delete shifts them down; both,
// and every rejected operation, give their result in the cycle after the item
// is accepted. A search compares every cell at once, then walks the match
// flags toward the head one cell per cycle; its result is registered when a
// match flag reaches the head or the scan reaches the last entry. A search on an
// empty list answers in the cycle after it is accepted.
// One item is in flight at a time: in_item.ready is high only when no search
// is scanning and the result register is empty or is being taken in the same
// cycle. A stalled out_item holds its result and blocks new items.
// Reset empties the list by clearing the count; entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_ordered_list_core_macros.svh"

module indexed_ordered_list_core #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  iol_in_if.sink    in_item,
  iol_out_if.source out_item
);
  import iol_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_cmd_t                    cmd;
  logic [CNT_W-1:0]             cell_pos;
  logic [CNT_W-1:0]             cnt;
  logic [VALUE_BITS+IN_VALUE_W-1:0] value_ext;
  logic [VALUE_BITS-1:0]        value;
  logic [VALUE_BITS-1:0]        cell_data [DEPTH];
  logic                         cell_match [DEPTH];

  assign value_ext = {{VALUE_BITS{in_item.data.value[IN_VALUE_W-1]}}, in_item.data.value};
  assign value     = value_ext[VALUE_BITS-1:0];

  iol_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .out_item   (out_item),
    .match_head (cell_match[0]),
    .cmd        (cmd),
    .cell_pos   (cell_pos),
    .cnt        (cnt)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_BITS-1:0] left_data;
    logic [VALUE_BITS-1:0] right_data;
    logic                  right_match;

    if (g == 0) begin : g_head
      assign left_data = value;
    end else begin : g_body
      assign left_data = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_data  = cell_data[g];
      assign right_match = 1'b0;
    end else begin : g_next
      assign right_data  = cell_data[g+1];
      assign right_match = cell_match[g+1];
    end

    iol_cell #(
      .IDX        (g),
      .CNT_W      (CNT_W),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (cell_pos),
      .cnt         (cnt),
      .value_in    (value),
      .left_data   (left_data),
      .right_data  (right_data),
      .right_match (right_match),
      .data        (cell_data[g]),
      .match       (cell_match[g])
    );
  end

  `IOL_ASSERT_IMP(a_count_bound, 1'b1, cnt <= DEPTH)
  `IOL_ASSERT_IMP(a_insert_room, cmd.ins, cnt < DEPTH)
  `IOL_ASSERT_NXT(a_insert_grows, cmd.ins, cnt == CNT_W'($past(cnt) + 1'b1))
  `IOL_ASSERT_NXT(a_delete_shrinks, cmd.del, cnt == CNT_W'($past(cnt) - 1'b1))
  `IOL_ASSERT_IMP(a_found_zero, out_item.valid && (out_item.data.status != ST_DONE),
                  out_item.data.found_position == '0)

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed ordered list core testbench
// Drives insert, delete and search items into the core. It keeps its own
// mirror of the list to predict each result, and checks every result field
// against that prediction. Both sides stall at random, and the result side
// also holds off for a long stretch.
// ----------------------------------------------------------------------------

module tb;
  import iol_pkg::*;

  localparam int          LIST_DEPTH    = 16;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int          STALL_LIMIT   = 3000;
  localparam int          DRAIN_CYCLES  = 24;
  localparam int          HOLD_CYCLES   = 150;

  logic clk = 1'b0;
  logic rst_n;

  iol_in_if  in_if ();
  iol_out_if out_if ();

  indexed_ordered_list_core #(
    .DEPTH      (LIST_DEPTH),
    .VALUE_BITS (32)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if)
  );

  always #4 clk = ~clk;

  logic signed [31:0] mirror_vals [LIST_DEPTH];
  int                 mirror_len;
  out_item_t          awaited_results [$];

  int in_idle_pct;
  int out_idle_pct;
  logic hold_out;
  int mismatches;
  int ops_sent;
  int results_checked;
  int full_hits;
  int idle_cycles;

  logic signed [31:0] value_pool [8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
                                         32'sd1, 32'sd42, -32'sd42, 32'sh0001_0000};

  function automatic out_item_t mirror_apply(in_item_t it);
    out_item_t r;
    int p;
    int i;
    logic hit;
    r.status = ST_REJECT;
    r.found_position = '0;
    p = it.position;
    hit = 1'b0;
    case (it.op)
      OP_INSERT: begin
        if (mirror_len < LIST_DEPTH && p <= mirror_len) begin
          for (i = mirror_len; i > p; i--) mirror_vals[i] = mirror_vals[i - 1];
          mirror_vals[p] = it.value;
          mirror_len++;
          if (mirror_len == LIST_DEPTH) full_hits++;
          r.status = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (p < mirror_len) begin
          for (i = p; i + 1 < mirror_len; i++) mirror_vals[i] = mirror_vals[i + 1];
          mirror_len--;
          r.status = ST_DONE;
        end
      end
      OP_SEARCH: begin
        r.status = ST_MISSING;
        for (i = 0; i < mirror_len; i++) begin
          if (!hit && mirror_vals[i] == it.value) begin
            hit = 1'b1;
            r.status = ST_DONE;
            r.found_position = i[FOUND_W-1:0];
          end
        end
      end
      default: r.status = ST_REJECT;
    endcase
    r.count = mirror_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      $display("[%0t] result item arrived with none outstanding", $realtime);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      results_checked++;
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.found_position !== want.found_position)
        report_mismatch("found_position", got.found_position, want.found_position);
      if (got.count !== want.count) report_mismatch("count", got.count, want.count);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_result(out_if.data);
    if (!rst_n || hold_out) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no item moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("** indexed_ordered_list_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_op(input logic [1:0] op, input int pos, input logic signed [31:0] val);
    in_item_t it;
    it.op = op;
    it.position = pos[POS_W-1:0];
    it.value = val;
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk); while (!in_if.ready);
    awaited_results.push_back(mirror_apply(it));
    ops_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(1)) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic logic signed [31:0] present_or_other();
    if (mirror_len > 0 && $urandom_range(3) != 0)
      return mirror_vals[$urandom_range(mirror_len - 1)];
    return pick_value();
  endfunction

  task automatic test_edges();
    send_op(OP_SEARCH, 0, 32'sh8000_0000);
    send_op(OP_DELETE, 0, 32'sd0);
    send_op(OP_INSERT, 1, 32'sd5);
    send_op(OP_INSERT, 0, 32'sh8000_0000);
    send_op(OP_INSERT, 1, 32'sh7fff_ffff);
    send_op(OP_INSERT, 0, 32'sd0);
    send_op(OP_INSERT, 3, -32'sd1);
    send_op(OP_SEARCH, 31, 32'sh7fff_ffff);
    send_op(OP_SEARCH, 0, -32'sd1);
    send_op(OP_SEARCH, 0, 32'sd5);
    send_op(OP_UNUSED, 31, -32'sd1);
    send_op(OP_DELETE, 31, -32'sd1);
    send_op(OP_INSERT, 31, 32'sd7);
    send_op(OP_DELETE, 4, 32'sd0);
    send_op(OP_INSERT, 5, 32'sd7);
    send_op(OP_DELETE, 0, 32'sd0);
    send_op(OP_SEARCH, 0, 32'sh8000_0000);
    send_op(OP_INSERT, 3, 32'sh8000_0000);
    send_op(OP_SEARCH, 0, 32'sh8000_0000);
    send_op(OP_DELETE, 3, 32'sd0);
  endtask

  task automatic test_fill_drain();
    while (mirror_len < LIST_DEPTH - 1)
      send_op(OP_INSERT, $urandom_range(mirror_len), pick_value());
    send_op(OP_INSERT, mirror_len, 32'sh1357_9bdf);
    send_op(OP_INSERT, $urandom_range(mirror_len), pick_value());
    send_op(OP_SEARCH, $urandom_range(31), 32'sh1357_9bdf);
    send_op(OP_SEARCH, 0, present_or_other());
    while (mirror_len > 0) begin
      if ($urandom_range(4) == 0) begin
        send_op(OP_SEARCH, $urandom_range(31), present_or_other());
      end else begin
        send_op(OP_DELETE, $urandom_range(mirror_len - 1), pick_value());
      end
    end
    send_op(OP_DELETE, 0, pick_value());
    send_op(OP_SEARCH, 0, pick_value());
  endtask

  task automatic test_random(input int n);
    int k;
    int r;
    int ins_cut;
    int del_cut;
    for (k = 0; k < n; k++) begin
      ins_cut = ((k / 40) % 2 == 0) ? 55 : 35;
      del_cut = ((k / 40) % 2 == 0) ? 70 : 75;
      r = $urandom_range(99);
      if (r < 10) begin
        case ($urandom_range(2))
          0: send_op(OP_UNUSED, $urandom_range(31), $urandom);
          1: send_op(OP_INSERT, $urandom_range(31), pick_value());
          default: send_op(OP_DELETE, $urandom_range(31), $urandom);
        endcase
      end else if (r < ins_cut) begin
        send_op(OP_INSERT, $urandom_range(mirror_len), pick_value());
      end else if (r < del_cut) begin
        send_op(OP_DELETE, (mirror_len > 0) ? $urandom_range(mirror_len - 1) : 0, $urandom);
      end else begin
        send_op(OP_SEARCH, $urandom_range(31), present_or_other());
      end
    end
  endtask

  task automatic test_backpressure();
    in_idle_pct = 0;
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
      test_random(40);
    join
  endtask

  task automatic run_phase(input int in_pct, input int out_pct);
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    test_random(150);
    test_fill_drain();
    test_random(150);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    hold_out <= 1'b0;
    in_idle_pct = 21;
    out_idle_pct = 75;
    mirror_len = 0;
    mismatches = 0;
    ops_sent = 0;
    results_checked = 0;
    full_hits = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edges();
    run_phase(21, 75);
    test_backpressure();
    run_phase(75, 21);
    run_phase(0, 0);
    test_fill_drain();

    in_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d list operations and checked %0d results; the list filled %0d times.",
             ops_sent, results_checked, full_hits);
    $display("Covered bad positions, unused opcodes, empty and full lists, and long stalls.");
    if (mismatches == 0) begin
      $display("** indexed_ordered_list_core: PASSED **");
    end else begin
      $display("** indexed_ordered_list_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/iol_pkg.sv
rtl/core/iol_in_if.sv
rtl/core/iol_out_if.sv
rtl/core/iol_cell.sv
rtl/core/iol_ctrl.sv
rtl/core/indexed_ordered_list_core.sv
test/tb.sv
